FILE: design/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg: shared definitions for the indexed list store
// Sizes, operation and status codes, sequencer states and the circular
// address helper used by the list store.
// ----------------------------------------------------------------------------
package ilst_pkg;

	// Maximum number of stored values (1 to 63).
	localparam int CAPACITY = 32;

	// Index into the entry memory and width of the fill count.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Payload field widths.
	localparam int KIND_W  = 3;
	localparam int POS_W   = 8;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 6;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 40;

	// Common compare width for position against the fill count.
	localparam int CMP_W = POS_W + 1;

	// Operation codes carried in the input tuser.
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FRONT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BACK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd4;

	// Status codes carried in the output tuser.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	// Value returned by a read that misses.
	localparam logic [VAL_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_EMIT,
		ST_SHF_RD,
		ST_SHF_WR,
		ST_DMP_RD,
		ST_DMP_EMIT
	} state_t;

	// Physical slot of a logical position, with the front at head.
	function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] lidx);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: design/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values
// Keeps up to CAPACITY values in a circular memory with a head pointer and
// serves read, insert front, append, remove and dump operations.
// ----------------------------------------------------------------------------
// One input transaction is taken while the block is idle, and the block is
// not ready again until the operation is finished and its result sits in the
// output register. The values live in a single-port-write, single-port-read
// memory addressed circularly from a head pointer, so an insert at the front
// or an append writes its entry without moving the others. A remove at the
// front or back only moves the head pointer or the count; a remove in the
// middle moves every later entry down by one through the memory read port,
// reading and then writing each moved entry. A dump reads each entry and
// delivers it as one result, waiting while the output side is held. Output
// back-pressure adds its own stall cycles. No clearing pass is needed after
// reset.
module indexed_list_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ilst_pkg::IN_W-1:0]   s_tdata,   // position [7:0], item_value [39:8]
	input  logic [2:0]                  s_tuser,   // kind [2:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ilst_pkg::OUT_W-1:0]  m_tdata,   // read_value [31:0], length [37:32],
	                                               // zero [39:38]
	output logic [1:0]                  m_tuser,   // status [1:0]
	output logic                        m_tlast
);

	ilst_pkg::state_t state_q, state_d;

	// Control registers.
	logic [ilst_pkg::IDX_W-1:0] head_q, head_d;
	logic [ilst_pkg::CNT_W-1:0] count_q, count_d;
	logic [ilst_pkg::IDX_W-1:0] idx_q, idx_d;

	// Pending single result.
	logic [ilst_pkg::VAL_W-1:0]  res_value_q, res_value_d;
	logic [ilst_pkg::STAT_W-1:0] res_status_q, res_status_d;

	// Output register.
	logic                        out_valid_q;
	logic [ilst_pkg::VAL_W-1:0]  out_value_q;
	logic [ilst_pkg::STAT_W-1:0] out_status_q;
	logic                        out_last_q;
	logic [ilst_pkg::LEN_W-1:0]  out_len_q;
	logic                        out_load;
	logic                        out_free;
	logic [ilst_pkg::VAL_W-1:0]  out_value_d;
	logic [ilst_pkg::STAT_W-1:0] out_status_d;
	logic                        out_last_d;

	// Entry memory.
	logic [ilst_pkg::VAL_W-1:0] mem [ilst_pkg::CAPACITY];
	logic                       mem_we;
	logic [ilst_pkg::IDX_W-1:0] mem_waddr;
	logic [ilst_pkg::VAL_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [ilst_pkg::IDX_W-1:0] mem_raddr;
	logic [ilst_pkg::VAL_W-1:0] rdata_q;

	// Input field decode.
	logic [ilst_pkg::KIND_W-1:0] in_kind;
	logic [ilst_pkg::POS_W-1:0]  in_pos;
	logic [ilst_pkg::VAL_W-1:0]  in_value;
	logic                        in_take;
	logic                        pos_in_range;
	logic                        pos_at_tail;
	logic                        is_full;
	logic [ilst_pkg::IDX_W-1:0]  head_dec;
	logic [ilst_pkg::IDX_W-1:0]  head_inc;
	logic [ilst_pkg::CNT_W-1:0]  idx_ext;
	logic                        dump_last;
	logic                        shift_done;

	assign in_kind  = s_tuser;
	assign in_pos   = s_tdata[7:0];
	assign in_value = s_tdata[39:8];

	assign s_tready = (state_q == ilst_pkg::ST_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Comparisons and helper addresses for the sequencer and the datapath.
	assign pos_in_range = (ilst_pkg::CMP_W'(in_pos) < ilst_pkg::CMP_W'(count_q));
	assign pos_at_tail  = (ilst_pkg::CMP_W'(in_pos) + ilst_pkg::CMP_W'(1)
			== ilst_pkg::CMP_W'(count_q));
	assign is_full      = (count_q == ilst_pkg::CNT_W'(ilst_pkg::CAPACITY));
	assign head_dec     = (head_q == '0) ? ilst_pkg::IDX_W'(ilst_pkg::CAPACITY - 1)
			: head_q - ilst_pkg::IDX_W'(1);
	assign head_inc     = ilst_pkg::phys_addr(head_q, ilst_pkg::CNT_W'(1));
	assign idx_ext      = ilst_pkg::CNT_W'(idx_q);
	assign dump_last    = (idx_ext + ilst_pkg::CNT_W'(1) == count_q);
	assign shift_done   = ((ilst_pkg::CNT_W+1)'(idx_q) + (ilst_pkg::CNT_W+1)'(2)
			>= (ilst_pkg::CNT_W+1)'(count_q));

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ilst_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = ilst_pkg::ST_EMIT;
					case (in_kind)
						ilst_pkg::KIND_READ: begin
							if (pos_in_range) begin
								state_d = ilst_pkg::ST_RD_WAIT;
							end
						end
						ilst_pkg::KIND_REMOVE: begin
							if (pos_in_range && in_pos != '0 && !pos_at_tail) begin
								state_d = ilst_pkg::ST_SHF_RD;
							end
						end
						ilst_pkg::KIND_DUMP: begin
							if (count_q != '0) begin
								state_d = ilst_pkg::ST_DMP_RD;
							end
						end
						default: begin
							state_d = ilst_pkg::ST_EMIT;
						end
					endcase
				end
			end
			ilst_pkg::ST_RD_WAIT: state_d = ilst_pkg::ST_EMIT;
			ilst_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = ilst_pkg::ST_IDLE;
				end
			end
			ilst_pkg::ST_SHF_RD: state_d = ilst_pkg::ST_SHF_WR;
			ilst_pkg::ST_SHF_WR: begin
				state_d = shift_done ? ilst_pkg::ST_EMIT : ilst_pkg::ST_SHF_RD;
			end
			ilst_pkg::ST_DMP_RD: state_d = ilst_pkg::ST_DMP_EMIT;
			ilst_pkg::ST_DMP_EMIT: begin
				if (out_free) begin
					state_d = dump_last ? ilst_pkg::ST_IDLE : ilst_pkg::ST_DMP_RD;
				end
			end
			default: state_d = ilst_pkg::ST_IDLE;
		endcase
	end

	// Datapath controls of the sequencer.
	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		idx_d        = idx_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_waddr    = ilst_pkg::phys_addr(head_q, idx_ext);
		mem_wdata    = rdata_q;
		mem_re       = 1'b0;
		mem_raddr    = ilst_pkg::phys_addr(head_q, idx_ext);
		out_load     = 1'b0;
		out_value_d  = res_value_q;
		out_status_d = res_status_q;
		out_last_d   = 1'b1;
		case (state_q)
			ilst_pkg::ST_IDLE: begin
				if (in_take) begin
					res_value_d  = '0;
					res_status_d = ilst_pkg::STAT_OK;
					idx_d        = ilst_pkg::IDX_W'(in_pos);
					case (in_kind)
						ilst_pkg::KIND_READ: begin
							if (pos_in_range) begin
								mem_re    = 1'b1;
								mem_raddr = ilst_pkg::phys_addr(head_q,
										ilst_pkg::CNT_W'(in_pos));
							end else begin
								res_value_d  = ilst_pkg::NEG_ONE;
								res_status_d = ilst_pkg::STAT_RANGE;
							end
						end
						ilst_pkg::KIND_FRONT: begin
							if (is_full) begin
								res_status_d = ilst_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = head_dec;
								mem_wdata = in_value;
								head_d    = head_dec;
								count_d   = count_q + ilst_pkg::CNT_W'(1);
							end
						end
						ilst_pkg::KIND_BACK: begin
							if (is_full) begin
								res_status_d = ilst_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = ilst_pkg::phys_addr(head_q, count_q);
								mem_wdata = in_value;
								count_d   = count_q + ilst_pkg::CNT_W'(1);
							end
						end
						ilst_pkg::KIND_REMOVE: begin
							if (!pos_in_range) begin
								res_status_d = ilst_pkg::STAT_RANGE;
							end else if (in_pos == '0) begin
								head_d  = head_inc;
								count_d = count_q - ilst_pkg::CNT_W'(1);
							end else if (pos_at_tail) begin
								count_d = count_q - ilst_pkg::CNT_W'(1);
							end
						end
						ilst_pkg::KIND_DUMP: begin
							idx_d = '0;
							if (count_q == '0) begin
								res_status_d = ilst_pkg::STAT_EMPTY;
							end
						end
						default: begin
							res_status_d = ilst_pkg::STAT_OK;
						end
					endcase
				end
			end
			ilst_pkg::ST_RD_WAIT: begin
				res_value_d = rdata_q;
			end
			ilst_pkg::ST_EMIT: begin
				out_load = out_free;
			end
			ilst_pkg::ST_SHF_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ilst_pkg::phys_addr(head_q, idx_ext + ilst_pkg::CNT_W'(1));
			end
			ilst_pkg::ST_SHF_WR: begin
				mem_we = 1'b1;
				idx_d  = idx_q + ilst_pkg::IDX_W'(1);
				if (shift_done) begin
					count_d = count_q - ilst_pkg::CNT_W'(1);
				end
			end
			ilst_pkg::ST_DMP_RD: begin
				mem_re = 1'b1;
			end
			ilst_pkg::ST_DMP_EMIT: begin
				out_load     = out_free;
				out_value_d  = rdata_q;
				out_status_d = ilst_pkg::STAT_OK;
				out_last_d   = dump_last;
				if (out_free) begin
					idx_d = idx_q + ilst_pkg::IDX_W'(1);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilst_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
		end
	end

	// Pending result fields.
	always_ff @(posedge clk) begin
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload. The length is the count after the operation.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= out_value_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
			out_len_q    <= ilst_pkg::LEN_W'(count_q);
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_len_q, out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q <= ilst_pkg::CNT_W'(ilst_pkg::CAPACITY))
		else $error("fill count exceeds capacity");

	// A result not marked last only appears while a dump is still running.
	a_nonlast_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid && !m_tlast) |-> (state_q == ilst_pkg::ST_DMP_RD ||
			state_q == ilst_pkg::ST_DMP_EMIT))
		else $error("non-final result outside a dump");

	// The memory is never written while a dump walks it.
	a_no_write_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ilst_pkg::ST_DMP_RD || state_q == ilst_pkg::ST_DMP_EMIT)
			|-> !mem_we)
		else $error("memory written during dump");

	// An accepted transaction leaves the count unchanged or moves it by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
			in_take |=> (count_q == $past(count_q) ||
			count_q == $past(count_q) + ilst_pkg::CNT_W'(1) ||
			count_q == $past(count_q) - ilst_pkg::CNT_W'(1)))
		else $error("count moved by more than one");
`endif

endmodule
